FILE: src/assert_macros.svh
// assertion macros used by the top-level rtl file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

FILE: src/mppmu_pkg.sv
// shared constants and types of the max-product potts message update block
// no dependencies
package mppmu_pkg;
    localparam int LABELS = 16;
    localparam int IDX_W = $clog2(LABELS);
    localparam int CNT_W = $clog2(LABELS + 1);
    localparam int VAL_W = 16;
    localparam int SUM_W = 24;
    localparam int FRAC = 14;
    localparam logic [15:0] ALPHA_ONE = 16'd32768;

    typedef logic [VAL_W-1:0] val_t;

    // saturating q2.14 product
    function automatic val_t qmul(input val_t x, input val_t y);
        logic [31:0] p;
        logic [17:0] s;
        begin
            p = {16'd0, x} * {16'd0, y};
            s = p[31:FRAC];
            qmul = (s > 18'd65535) ? 16'hFFFF : s[15:0];
        end
    endfunction
endpackage

FILE: src/maxproduct_potts_message_update_core.sv
// top level of the max-product potts message update block
// depends on mppmu_pkg, mppmu_ram, mppmu_div, assert_macros.svh
//
// Labels are taken one at a time: a new one is accepted only in the idle state,
// after the last one has passed state WR. Each product a*b*c*ev is formed at the
// accept and in states M1 and M2, and written, with the previous message, to a
// label store in state WR after M3, unless the store is full. The item marked
// last triggers two passes over the store: a sum pass, then an emit pass in which
// each label goes through a serial divider and waits while a result in the
// output register is not taken. No item is taken while a node's passes run. A
// result waiting in the output register does not hold the input.
`include "assert_macros.svh"
module maxproduct_potts_message_update_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // msg_a, msg_b, msg_c, evidence, prev_msg, same_weight, diff_weight
    input  logic [111:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // msg_value, label_index, zero_total (pad to 24 bits)
    output logic [23:0] m_axis_tdata,
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);
    localparam logic [3:0] S_IDLE = 4'd0, S_M1 = 4'd1, S_M2 = 4'd2, S_M3 = 4'd3,
        S_WR = 4'd4, S_SRD = 4'd5, S_SACC = 4'd6, S_ERD = 4'd7, S_EMAX = 4'd8,
        S_DIV = 4'd9, S_DAMP = 4'd10, S_OUT = 4'd11;
    localparam int IW = mppmu_pkg::IDX_W;
    localparam int CW = mppmu_pkg::CNT_W;

    logic [3:0] st_reg, st_next;
    logic [15:0] alpha_reg;
    logic [15:0] p_reg, ev_reg, c_reg, prev_reg, same_reg, diff_reg;
    logic last_reg;
    logic [15:0] top_reg, sec_reg;
    logic [IW-1:0] topi_reg;
    logic [CW-1:0] cnt_reg;
    logic [IW-1:0] j_reg;
    logic [mppmu_pkg::SUM_W-1:0] sum_reg;
    logic [15:0] q_reg;
    logic [15:0] ov_reg;
    logic [IW-1:0] oi_reg;
    logic oz_reg, ol_reg, ovld_reg;
    logic [15:0] hrd, prd;
    logic [IW-1:0] raddr;
    logic we;
    logic [15:0] s_v, d_v, o_v, a_sat;
    logic dv_done;
    logic [15:0] dv_q;
    logic [32:0] damp;

    assign s_axis_tready = (st_reg == S_IDLE);
    wire acc = s_axis_tvalid && s_axis_tready;
    wire full = (cnt_reg == CW'(mppmu_pkg::LABELS));
    assign we = (st_reg == S_WR) && !full;
    assign raddr = j_reg;

    mppmu_ram #(.WIDTH(16), .DEPTH(mppmu_pkg::LABELS)) u_hram (
        .clk(clk), .we(we), .waddr(cnt_reg[IW-1:0]), .wdata(p_reg),
        .raddr(raddr), .rdata(hrd));
    mppmu_ram #(.WIDTH(16), .DEPTH(mppmu_pkg::LABELS)) u_pram (
        .clk(clk), .we(we), .waddr(cnt_reg[IW-1:0]), .wdata(prev_reg),
        .raddr(raddr), .rdata(prd));

    assign s_v = mppmu_pkg::qmul(hrd, same_reg);
    assign d_v = mppmu_pkg::qmul((j_reg == topi_reg && cnt_reg > CW'(1)) ? sec_reg :
        (cnt_reg == CW'(1) ? 16'd0 : top_reg), diff_reg);
    assign o_v = (s_v > d_v) ? s_v : d_v;
    assign a_sat = (alpha_reg > mppmu_pkg::ALPHA_ONE) ? mppmu_pkg::ALPHA_ONE : alpha_reg;

    mppmu_div u_div (.clk(clk), .rst_n(rst_n), .start(st_reg == S_EMAX),
        .num(o_v), .den(sum_reg), .done(dv_done), .quot(dv_q));

    assign damp = {17'd0, a_sat} * {17'd0, (sum_reg == '0) ? 16'd0 : q_reg}
        + {17'd0, mppmu_pkg::ALPHA_ONE - a_sat} * {17'd0, prev_reg};

    wire emit_ok = !ovld_reg || m_axis_tready;

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            S_IDLE: if (acc) st_next = S_M1;
            S_M1: st_next = S_M2;
            S_M2: st_next = S_M3;
            S_M3: st_next = S_WR;
            S_WR: st_next = last_reg ? S_SRD : S_IDLE;
            S_SRD: st_next = S_SACC;
            S_SACC: st_next = (32'(j_reg) + 1 == 32'(cnt_reg)) ? S_ERD : S_SRD;
            S_ERD: st_next = S_EMAX;
            S_EMAX: st_next = S_DIV;
            S_DIV: if (dv_done) st_next = S_DAMP;
            S_DAMP: st_next = S_OUT;
            S_OUT: if (emit_ok)
                st_next = (32'(j_reg) + 1 == 32'(cnt_reg)) ? S_IDLE : S_ERD;
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            alpha_reg <= mppmu_pkg::ALPHA_ONE;
            top_reg <= '0;
            sec_reg <= '0;
            topi_reg <= '0;
            cnt_reg <= '0;
            j_reg <= '0;
            sum_reg <= '0;
            ovld_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (cfg_we)
            begin
                alpha_reg <= cfg_wdata;
            end
            if (st_reg == S_OUT && emit_ok)
            begin
                ovld_reg <= 1'b1;
            end
            else if (ovld_reg && m_axis_tready)
            begin
                ovld_reg <= 1'b0;
            end
            case (st_reg)
                S_WR:
                begin
                    if (!full)
                    begin
                        if (p_reg > top_reg)
                        begin
                            sec_reg <= top_reg;
                            top_reg <= p_reg;
                            topi_reg <= cnt_reg[IW-1:0];
                        end
                        else if (p_reg > sec_reg)
                        begin
                            sec_reg <= p_reg;
                        end
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                    j_reg <= '0;
                    sum_reg <= '0;
                end
                S_SACC:
                begin
                    sum_reg <= sum_reg + mppmu_pkg::SUM_W'(o_v);
                    j_reg <= (st_next == S_ERD) ? '0 : j_reg + IW'(1);
                end
                S_OUT:
                begin
                    if (emit_ok)
                    begin
                        j_reg <= (st_next == S_IDLE) ? '0 : j_reg + IW'(1);
                        if (st_next == S_IDLE)
                        begin
                            top_reg <= '0;
                            sec_reg <= '0;
                            topi_reg <= '0;
                            cnt_reg <= '0;
                            sum_reg <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            p_reg <= mppmu_pkg::qmul(s_axis_tdata[15:0], s_axis_tdata[31:16]);
            c_reg <= s_axis_tdata[47:32];
            ev_reg <= s_axis_tdata[63:48];
            prev_reg <= s_axis_tdata[79:64];
            same_reg <= s_axis_tdata[95:80];
            diff_reg <= s_axis_tdata[111:96];
            last_reg <= s_axis_tlast;
        end
        if (st_reg == S_M1) p_reg <= mppmu_pkg::qmul(p_reg, c_reg);
        if (st_reg == S_M2) p_reg <= mppmu_pkg::qmul(p_reg, ev_reg);
        if (st_reg == S_EMAX)
        begin
            prev_reg <= prd;
        end
        if (dv_done) q_reg <= dv_q;
        if (st_reg == S_DAMP)
        begin
            ov_reg <= (damp[32:15] > 18'd65535) ? 16'hFFFF : damp[30:15];
            oi_reg <= j_reg;
        end
        if (st_reg == S_OUT && emit_ok)
        begin
            oz_reg <= (sum_reg == '0);
            ol_reg <= (32'(j_reg) + 1 == 32'(cnt_reg));
        end
    end

    wire [15:0] ov_hold = ov_reg;
    logic [15:0] mv_reg;
    logic [IW-1:0] mi_reg;
    always_ff @(posedge clk)
    begin
        if (st_reg == S_OUT && emit_ok)
        begin
            mv_reg <= ov_hold;
            mi_reg <= oi_reg;
        end
    end

    assign m_axis_tvalid = ovld_reg;
    assign m_axis_tdata = {1'b0, oz_reg, 6'(mi_reg), mv_reg};
    assign m_axis_tlast = ol_reg;

    `ASSERT_IMPL(a_no_accept_busy, clk, rst_n, st_reg != S_IDLE, !s_axis_tready)
    `ASSERT_IMPL(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg <= CW'(mppmu_pkg::LABELS))
    `ASSERT_NEXT(a_out_clear, clk, rst_n, st_reg == S_OUT && st_next == S_IDLE, cnt_reg == '0)
endmodule

FILE: src/mppmu_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module mppmu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: src/mppmu_div.sv
// restoring divider: floor(num * 2^14 / den), one quotient bit a cycle
// depends on mppmu_pkg
module mppmu_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [15:0]           num,
    input  logic [mppmu_pkg::SUM_W-1:0] den,
    output logic                  done,
    output logic [15:0]           quot
);
    localparam int NB = 30;
    logic [NB-1:0] dvd_reg, dvd_next;
    logic [mppmu_pkg::SUM_W:0] rem_reg, rem_next;
    logic [mppmu_pkg::SUM_W-1:0] den_reg, den_next;
    logic [4:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic [mppmu_pkg::SUM_W:0] sh;

    always_comb
    begin
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        sh = {rem_reg[mppmu_pkg::SUM_W-1:0], dvd_reg[NB-1]};
        done = 1'b0;
        if (start)
        begin
            dvd_next = {num, 14'd0};
            rem_next = '0;
            den_next = den;
            cnt_next = 5'(NB);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (sh >= {1'b0, den_reg})
            begin
                rem_next = sh - {1'b0, den_reg};
                dvd_next = {dvd_reg[NB-2:0], 1'b1};
            end
            else
            begin
                rem_next = sh;
                dvd_next = {dvd_reg[NB-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
                done = 1'b1;
            end
        end
    end

    // quotient fits 16 bits since num <= sum
    assign quot = dvd_next[15:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end
endmodule

FILE: tb/maxproduct_potts_message_update_core_test.sv
// testbench for maxproduct_potts_message_update_core: random and directed label streams
// checked against an in-house max-product message predictor held in a scoreboard class
// depends on mppmu_pkg and the core rtl
`timescale 1ns / 100ps
module maxproduct_potts_message_update_core_test;
    localparam int WATCHDOG_LIMIT = 6000;
    localparam int DRAIN_CYCLES = 700;

    typedef struct {
        logic [15:0] value;
        logic [5:0]  label;
        logic        zero;
        logic        last;
    } msg_out_t;

    class potts_scoreboard;
        logic [15:0] alpha;
        logic [15:0] h_store[mppmu_pkg::LABELS];
        logic [15:0] prev_store[mppmu_pkg::LABELS];
        logic [15:0] top_h;
        logic [15:0] second_h;
        int          top_label;
        int          count;
        msg_out_t    expected_msgs[$];

        function new();
            alpha = mppmu_pkg::ALPHA_ONE;
            top_h = 0;
            second_h = 0;
            top_label = 0;
            count = 0;
        endfunction

        function logic [15:0] qprod(logic [15:0] x, logic [15:0] y);
            logic [31:0] p;
            p = ({16'd0, x} * {16'd0, y}) >> mppmu_pkg::FRAC;
            return (p > 32'd65535) ? 16'hFFFF : p[15:0];
        endfunction

        function void note_label(logic [111:0] data, logic last_in);
            logic [15:0] h, same_w, diff_w, other, s, d;
            logic [15:0] outv[mppmu_pkg::LABELS];
            logic [31:0] sum;
            logic [63:0] norm, v;
            logic [15:0] a;
            msg_out_t m;
            h = qprod(qprod(qprod(data[15:0], data[31:16]), data[47:32]), data[63:48]);
            same_w = data[95:80];
            diff_w = data[111:96];
            if (count < mppmu_pkg::LABELS)
            begin
                h_store[count] = h;
                prev_store[count] = data[79:64];
                if (h > top_h)
                begin
                    second_h = top_h;
                    top_h = h;
                    top_label = count;
                end
                else if (h > second_h)
                    second_h = h;
                count++;
            end
            if (!last_in)
                return;
            sum = 0;
            for (int j = 0; j < count; j++)
            begin
                other = (j == top_label) ? second_h : top_h;
                s = qprod(h_store[j], same_w);
                d = qprod(other, diff_w);
                outv[j] = (s > d) ? s : d;
                sum += outv[j];
            end
            a = (alpha > mppmu_pkg::ALPHA_ONE) ? mppmu_pkg::ALPHA_ONE : alpha;
            for (int j = 0; j < count; j++)
            begin
                norm = (sum == 0) ? 64'd0 : ({48'd0, outv[j]} << mppmu_pkg::FRAC) / sum;
                v = (a * norm + (64'd32768 - a) * prev_store[j]) >> 15;
                m.value = (v > 64'd65535) ? 16'hFFFF : v[15:0];
                m.label = 6'(j);
                m.zero = (sum == 0);
                m.last = (j + 1 == count);
                expected_msgs.push_back(m);
            end
            top_h = 0;
            second_h = 0;
            top_label = 0;
            count = 0;
        endfunction

        function string check_msg(logic [23:0] data, logic last_out);
            msg_out_t m;
            if (expected_msgs.size() == 0)
                return $sformatf("unexpected item value=%0d label=%0d",
                    data[15:0], data[21:16]);
            m = expected_msgs.pop_front();
            if (data[15:0] !== m.value || data[21:16] !== m.label || data[22] !== m.zero
                || last_out !== m.last)
                return $sformatf({"label %0d: got value=%0d label=%0d zero=%b last=%b, ",
                    "want %0d %0d %b %b"},
                    m.label, data[15:0], data[21:16], data[22], last_out,
                    m.value, m.label, m.zero, m.last);
            return "";
        endfunction
    endclass

    logic         clk = 0;
    logic         rst_n = 0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [111:0] s_axis_tdata = '0;
    logic         s_axis_tlast = 0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [23:0]  m_axis_tdata;
    logic         m_axis_tlast;
    logic         cfg_we = 0;
    logic [15:0]  cfg_wdata = '0;

    potts_scoreboard sb = new();
    int mismatches = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_cycles = 0;
    int quiet_cycles = 0;
    logic [111:0] prev_data = '0;

    maxproduct_potts_message_update_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always #5 clk = ~clk;

    task automatic report(string msg);
        $display("MISMATCH: %s", msg);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            m_axis_tready <= 0;
            hold_cycles <= hold_cycles - 1;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        string msg;
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_label(s_axis_tdata, s_axis_tlast);
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            msg = sb.check_msg(m_axis_tdata, m_axis_tlast);
            if (msg != "")
                report(msg);
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // valid stays high after an accept until the next item replaces the data or an idle phase or wait_drained drops it
    task automatic send_label(logic [111:0] data, logic last_in);
        if ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= data;
        s_axis_tlast <= last_in;
        do @(posedge clk); while (!s_axis_tready);
        prev_data = data;
    endtask

    function automatic logic [15:0] pick_value();
        case ($urandom_range(5))
            0: return 16'($urandom_range(65535));
            1: return $urandom_range(1) ? 16'hFFFF : 16'd0;
            2: return 16'd16384;
            default: return 16'($urandom_range(24576, 8192));
        endcase
    endfunction

    function automatic logic [111:0] make_label();
        logic [111:0] d;
        for (int f = 0; f < 7; f++)
            d[f*16 +: 16] = pick_value();
        if ($urandom_range(7) == 0)
            d[63:0] = prev_data[63:0];
        if ($urandom_range(15) == 0)
            d[63:48] = '0;
        return d;
    endfunction

    task automatic send_node(int n);
        for (int k = 0; k < n; k++)
            send_label(make_label(), k == n - 1);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 0;
        @(posedge clk);
        while (sb.expected_msgs.size() != 0) @(posedge clk);
    endtask

    task automatic write_alpha(logic [15:0] value);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we <= 1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 0;
        sb.alpha = value;
    endtask

    task automatic run_phase(logic [15:0] alpha, int idle, int stall, int items);
        int sent;
        int n;
        write_alpha(alpha);
        idle_pct = idle;
        stall_pct = stall;
        sent = 0;
        while (sent < items)
        begin
            n = ($urandom_range(9) == 0) ? $urandom_range(20, 17) : $urandom_range(16, 1);
            send_node(n);
            sent += n;
        end
    endtask

    initial
    begin
        logic [111:0] d;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: extremes, zero sum, ties, single label, overflow of the store
        send_label({7{16'hFFFF}}, 1);
        send_label(112'd0, 1);
        send_label({16'd0, 16'd0, {5{16'd16384}}}, 0);
        send_label({16'd8192, 16'd16384, {5{16'd16384}}}, 1);
        d = {16'd4096, 16'd16384, 16'd1000, {4{16'd20000}}};
        send_label(d, 0);
        send_label(d, 0);
        send_label(d, 1);
        for (int k = 0; k < 18; k++)
            send_label(make_label(), k == 17);

        run_phase(16'd32768, 0, 0, 80);
        run_phase(16'd0, 62, 0, 80);
        run_phase(16'd40000, 0, 62, 80);
        run_phase(16'd65535, 27, 27, 70);

        write_alpha(16'd12345);
        idle_pct = 0;
        stall_pct = 0;
        hold_cycles = 500;
        send_node(16);
        send_node(16);
        wait_drained();
        send_node(12);
        run_phase(16'd1, 62, 62, 80);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
